// ===== hdl/aarm_pkg.sv =====
// Package with constants, payload types and arithmetic helpers of the rotation matrix unit.
`default_nettype none
package aarm_pkg;

  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_FRAC    = 12;
  localparam int NORM_GUARD    = 8;

  localparam int AXIS_W  = 16;
  localparam int N2_W    = 32;
  localparam int RAD_W   = 48;
  localparam int ROOT_W  = 24;
  localparam int REM_W   = 25;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DEN_W   = ROOT_W + 1;
  localparam int Q_W     = 15;
  localparam int DIV_STEPS = Q_W;
  localparam int NUM_W   = 39;
  localparam int CW      = 36;
  localparam int PW      = 22;

  localparam logic signed [CW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [CW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [CW-1:0] Q30_GAIN    = 36'sd652032874;
  localparam logic [N2_W-1:0]      N2_ONE      = N2_W'(64'd1 << (2 * FRAC_BITS));

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic signed [AXIS_W-1:0] angle_rad;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_item_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    logic signed [CW-1:0]     ang;
    logic                     skip;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [REM_W-1:0] r;
    logic [Q_W-1:0]   nl;
    logic [Q_W-1:0]   q;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [2:0]   lane;
    logic [DEN_W-1:0]  den;
  } div_st_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ang;
    logic                 flip;
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] z;
  } cordic_st_t;

  typedef struct packed {
    logic signed [PW-1:0] c;
    logic signed [PW-1:0] txx;
    logic signed [PW-1:0] tyy;
    logic signed [PW-1:0] tzz;
    logic signed [PW-1:0] txy;
    logic signed [PW-1:0] txz;
    logic signed [PW-1:0] tyz;
    logic signed [PW-1:0] sx;
    logic signed [PW-1:0] sy;
    logic signed [PW-1:0] sz;
  } mat_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [PW-1:0] mulq(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b);
    logic signed [2*PW-1:0] p;
    p = a * b;
    p = p + ((2*PW)'(1) <<< (FRAC_BITS - 1));
    return PW'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [PW:0] v);
    logic signed [15:0] r;
    if (v > (PW+1)'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -(PW+1)'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aarm_sqrt_cell.sv =====
// One cell of the square root chain: yields one root bit per cycle while en is high.
`default_nettype none
module aarm_sqrt_cell import aarm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     i_valid,
  input  wire sqrt_st_t i_st,
  input  wire side_t    i_side,
  output logic          o_valid,
  output sqrt_st_t      o_st,
  output side_t         o_side
);

  logic          valid_r;
  sqrt_st_t      st_r, st_nxt;
  side_t         side_r;
  logic [REM_W+1:0] r2, trial;

  always_comb begin
    r2    = {i_st.rem, i_st.rad[RAD_W-1 -: 2]};
    trial = {1'b0, i_st.root, 2'b01};
    st_nxt.rad = {i_st.rad[RAD_W-3:0], 2'b00};
    if (r2 >= trial) begin
      st_nxt.rem  = REM_W'(r2 - trial);
      st_nxt.root = {i_st.root[ROOT_W-2:0], 1'b1};
    end else begin
      st_nxt.rem  = REM_W'(r2);
      st_nxt.root = {i_st.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r   <= st_nxt;
      side_r <= i_side;
    end
  end

  assign o_valid = valid_r;
  assign o_st    = st_r;
  assign o_side  = side_r;

endmodule
`default_nettype wire

// ===== hdl/aarm_div_cell.sv =====
// One cell of the divider chain: yields one quotient bit per cycle for each axis component while en is high.
`default_nettype none
module aarm_div_cell import aarm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    i_valid,
  input  wire div_st_t i_st,
  input  wire side_t   i_side,
  output logic         o_valid,
  output div_st_t      o_st,
  output side_t        o_side
);

  logic          valid_r;
  div_st_t       st_r, st_nxt;
  side_t         side_r;
  logic [REM_W:0] r2 [3];

  always_comb begin
    st_nxt.den = i_st.den;
    for (int k = 0; k < 3; k++) begin
      r2[k] = {i_st.lane[k].r, i_st.lane[k].nl[Q_W-1]};
      st_nxt.lane[k].nl = {i_st.lane[k].nl[Q_W-2:0], 1'b0};
      if (r2[k] >= {1'b0, i_st.den}) begin
        st_nxt.lane[k].r = REM_W'(r2[k] - {1'b0, i_st.den});
        st_nxt.lane[k].q = {i_st.lane[k].q[Q_W-2:0], 1'b1};
      end else begin
        st_nxt.lane[k].r = REM_W'(r2[k]);
        st_nxt.lane[k].q = {i_st.lane[k].q[Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r   <= st_nxt;
      side_r <= i_side;
    end
  end

  assign o_valid = valid_r;
  assign o_st    = st_r;
  assign o_side  = side_r;

endmodule
`default_nettype wire

// ===== hdl/aarm_cordic_cell.sv =====
// One rotation-mode CORDIC cell; the cell position sets its shift and arctangent.
`default_nettype none
module aarm_cordic_cell import aarm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic [4:0] idx,
  input  wire logic       i_valid,
  input  wire cordic_st_t i_st,
  output logic            o_valid,
  output cordic_st_t      o_st
);

  logic                 valid_r;
  cordic_st_t           st_r, st_nxt;
  logic signed [CW-1:0] dx, dy, at;

  always_comb begin
    dx = i_st.sy >>> idx;
    dy = i_st.cx >>> idx;
    at = signed'({{(CW-32){1'b0}}, atan_q30(idx)});
    st_nxt = i_st;
    if (!i_st.ang[CW-1]) begin
      st_nxt.cx  = i_st.cx - dx;
      st_nxt.sy  = i_st.sy + dy;
      st_nxt.ang = i_st.ang - at;
    end else begin
      st_nxt.cx  = i_st.cx + dx;
      st_nxt.sy  = i_st.sy - dy;
      st_nxt.ang = i_st.ang + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_st    = st_r;

endmodule
`default_nettype wire

// ===== hdl/aarm_mat.sv =====
// Rounding of sine and cosine and the two product stages of the matrix entries.
`default_nettype none
module aarm_mat import aarm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic       i_valid,
  input  wire cordic_st_t i_st,
  output logic            o_valid,
  output mat_t            o_mat
);

  localparam int RSH = 30 - FRAC_BITS;

  logic [2:0]           valid_r;
  logic signed [CW-1:0] cf, sf;
  logic signed [PW-1:0] c_nxt, s_nxt;
  logic signed [PW-1:0] c_r, s_r, t_r, x_r, y_r, z_r;
  logic signed [PW-1:0] c1_r, tx_r, ty_r, tz_r, x1_r, y1_r, z1_r, sx_r, sy_r, sz_r;
  mat_t                 mat_r;

  always_comb begin
    cf = i_st.flip ? -i_st.cx : i_st.cx;
    sf = i_st.flip ? -i_st.sy : i_st.sy;
    c_nxt = PW'((cf + (CW'(1) <<< (RSH - 1))) >>> RSH);
    s_nxt = PW'((sf + (CW'(1) <<< (RSH - 1))) >>> RSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
      s_r <= s_nxt;
      t_r <= (PW'(1) <<< FRAC_BITS) - c_nxt;
      x_r <= i_st.x;
      y_r <= i_st.y;
      z_r <= i_st.z;

      c1_r <= c_r;
      tx_r <= mulq(t_r, x_r);
      ty_r <= mulq(t_r, y_r);
      tz_r <= mulq(t_r, z_r);
      sx_r <= mulq(s_r, x_r);
      sy_r <= mulq(s_r, y_r);
      sz_r <= mulq(s_r, z_r);
      x1_r <= x_r;
      y1_r <= y_r;
      z1_r <= z_r;

      mat_r.c   <= c1_r;
      mat_r.txx <= mulq(tx_r, x1_r);
      mat_r.tyy <= mulq(ty_r, y1_r);
      mat_r.tzz <= mulq(tz_r, z1_r);
      mat_r.txy <= mulq(tx_r, y1_r);
      mat_r.txz <= mulq(tx_r, z1_r);
      mat_r.tyz <= mulq(ty_r, z1_r);
      mat_r.sx  <= sx_r;
      mat_r.sy  <= sy_r;
      mat_r.sz  <= sz_r;
    end
  end

  assign o_valid = valid_r[2];
  assign o_mat   = mat_r;

endmodule
`default_nettype wire

// ===== hdl/axis_angle_rotation_matrix_unit.sv =====
// Top level of the axis-angle to rotation matrix unit: cell chains, setup stages and output register.
//
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall   | in_item_t: axis_x, axis_y, axis_z, angle_rad
// out_    | output    | out_valid/out_stall | out_item_t: m00 .. m22
//
// One transaction is accepted per cycle while the output is not stalled.
// Its path runs through the input stage, the 24 square root cells, 15 divider cells,
// 16 CORDIC cells, the rounding and product stages of the matrix block and the output register.
// A stalled output freezes the whole chain, and in_stall follows that condition.
// Reset is synchronous and clears only the valid bits.
`default_nettype none
module axis_angle_rotation_matrix_unit import aarm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  logic en;

  logic                     s0_valid_r;
  sqrt_st_t                 s0_st_r;
  side_t                    s0_side_r, s0_side_nxt;
  logic signed [2*AXIS_W-1:0] px, py, pz;
  logic [N2_W-1:0]          n2;
  logic signed [CW-1:0]     ang0;

  logic       sq_v    [SQRT_STEPS+1];
  sqrt_st_t   sq_st   [SQRT_STEPS+1];
  side_t      sq_side [SQRT_STEPS+1];
  logic       dv_v    [DIV_STEPS+1];
  div_st_t    dv_st   [DIV_STEPS+1];
  side_t      dv_side [DIV_STEPS+1];
  logic       cd_v    [CORDIC_STAGES+1];
  cordic_st_t cd_st   [CORDIC_STAGES+1];

  logic [AXIS_W-1:0]    mag   [3];
  logic [NUM_W-1:0]     num   [3];
  logic signed [PW-1:0] nrm   [3];
  logic signed [AXIS_W-1:0] raw [3];
  logic signed [CW-1:0] angf;

  logic      mat_v;
  mat_t      mat;
  logic      out_valid_r;
  out_item_t out_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_comb begin
    px = in_data.axis_x * in_data.axis_x;
    py = in_data.axis_y * in_data.axis_y;
    pz = in_data.axis_z * in_data.axis_z;
    n2 = N2_W'(px) + N2_W'(py) + N2_W'(pz);
    ang0 = {{(CW-AXIS_W-(30-ANGLE_FRAC)){in_data.angle_rad[AXIS_W-1]}},
            in_data.angle_rad, {(30-ANGLE_FRAC){1'b0}}};
    s0_side_nxt.x    = in_data.axis_x;
    s0_side_nxt.y    = in_data.axis_y;
    s0_side_nxt.z    = in_data.axis_z;
    s0_side_nxt.skip = (n2 == N2_ONE) || (n2 <= N2_W'(1));
    if (ang0 > Q30_PI) begin
      s0_side_nxt.ang = ang0 - (Q30_PI <<< 1);
    end else if (ang0 < -Q30_PI) begin
      s0_side_nxt.ang = ang0 + (Q30_PI <<< 1);
    end else begin
      s0_side_nxt.ang = ang0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_st_r.rad  <= {n2, {(RAD_W-N2_W){1'b0}}};
      s0_st_r.rem  <= '0;
      s0_st_r.root <= '0;
      s0_side_r    <= s0_side_nxt;
    end
  end

  assign sq_v[0]    = s0_valid_r;
  assign sq_st[0]   = s0_st_r;
  assign sq_side[0] = s0_side_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    aarm_sqrt_cell u_cell (
      .clk, .rst_n, .en,
      .i_valid(sq_v[k]),   .i_st(sq_st[k]),   .i_side(sq_side[k]),
      .o_valid(sq_v[k+1]), .o_st(sq_st[k+1]), .o_side(sq_side[k+1])
    );
  end

  assign raw[0] = sq_side[SQRT_STEPS].x;
  assign raw[1] = sq_side[SQRT_STEPS].y;
  assign raw[2] = sq_side[SQRT_STEPS].z;

  always_comb begin
    dv_st[0].den = {sq_st[SQRT_STEPS].root, 1'b0};
    for (int k = 0; k < 3; k++) begin
      mag[k] = raw[k][AXIS_W-1] ? AXIS_W'(-raw[k]) : AXIS_W'(raw[k]);
      num[k] = {mag[k], {(FRAC_BITS+NORM_GUARD+1){1'b0}}} +
               NUM_W'(sq_st[SQRT_STEPS].root);
      dv_st[0].lane[k].r  = REM_W'(num[k][NUM_W-1:Q_W]);
      dv_st[0].lane[k].nl = num[k][Q_W-1:0];
      dv_st[0].lane[k].q  = '0;
    end
  end

  assign dv_v[0]    = sq_v[SQRT_STEPS];
  assign dv_side[0] = sq_side[SQRT_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    aarm_div_cell u_cell (
      .clk, .rst_n, .en,
      .i_valid(dv_v[k]),   .i_st(dv_st[k]),   .i_side(dv_side[k]),
      .o_valid(dv_v[k+1]), .o_st(dv_st[k+1]), .o_side(dv_side[k+1])
    );
  end

  always_comb begin
    nrm[0] = PW'(dv_side[DIV_STEPS].x);
    nrm[1] = PW'(dv_side[DIV_STEPS].y);
    nrm[2] = PW'(dv_side[DIV_STEPS].z);
    for (int k = 0; k < 3; k++) begin
      if (!dv_side[DIV_STEPS].skip) begin
        nrm[k] = nrm[k][PW-1] ? -signed'(PW'(dv_st[DIV_STEPS].lane[k].q))
                              : signed'(PW'(dv_st[DIV_STEPS].lane[k].q));
      end
    end
    angf = dv_side[DIV_STEPS].ang;
    cd_st[0].flip = 1'b0;
    if (angf > Q30_HALF_PI) begin
      angf = angf - Q30_PI;
      cd_st[0].flip = 1'b1;
    end else if (angf < -Q30_HALF_PI) begin
      angf = angf + Q30_PI;
      cd_st[0].flip = 1'b1;
    end
    cd_st[0].ang = angf;
    cd_st[0].cx  = Q30_GAIN;
    cd_st[0].sy  = '0;
    cd_st[0].x   = nrm[0];
    cd_st[0].y   = nrm[1];
    cd_st[0].z   = nrm[2];
  end

  assign cd_v[0] = dv_v[DIV_STEPS];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    aarm_cordic_cell u_cell (
      .clk, .rst_n, .en,
      .idx(5'(k)),
      .i_valid(cd_v[k]),   .i_st(cd_st[k]),
      .o_valid(cd_v[k+1]), .o_st(cd_st[k+1])
    );
  end

  aarm_mat u_mat (
    .clk, .rst_n, .en,
    .i_valid(cd_v[CORDIC_STAGES]),
    .i_st(cd_st[CORDIC_STAGES]),
    .o_valid(mat_v),
    .o_mat(mat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mat_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.m00 <= sat16((PW+1)'(mat.c) + (PW+1)'(mat.txx));
      out_r.m01 <= sat16((PW+1)'(mat.txy) + (PW+1)'(mat.sz));
      out_r.m02 <= sat16((PW+1)'(mat.txz) - (PW+1)'(mat.sy));
      out_r.m10 <= sat16((PW+1)'(mat.txy) - (PW+1)'(mat.sz));
      out_r.m11 <= sat16((PW+1)'(mat.c) + (PW+1)'(mat.tyy));
      out_r.m12 <= sat16((PW+1)'(mat.tyz) + (PW+1)'(mat.sx));
      out_r.m20 <= sat16((PW+1)'(mat.txz) + (PW+1)'(mat.sy));
      out_r.m21 <= sat16((PW+1)'(mat.tyz) - (PW+1)'(mat.sx));
      out_r.m22 <= sat16((PW+1)'(mat.c) + (PW+1)'(mat.tzz));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== hdl/aarm_checker.sv =====
// Port-level checker of the rotation matrix unit and its bind to the top level.
`default_nettype none
module aarm_checker import aarm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the output stall");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_data))
    else $error("in_data unknown while in_valid is high");

endmodule

bind axis_angle_rotation_matrix_unit aarm_checker u_aarm_checker (.*);
`default_nettype wire
